FILE: rtl/calibrated_block_average_detector_assert.svh
// Assertion macros shared by the detector RTL.
// Used by cbad_ctrl and cbad_dp; NO_ASSERTIONS compiles them out.
`ifndef CALIBRATED_BLOCK_AVERAGE_DETECTOR_ASSERT_SVH
`define CALIBRATED_BLOCK_AVERAGE_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication or plain invariant
`define CBAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle, consequent next cycle
`define CBAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define CBAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/cbad_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the block-average detector.
// No dependencies; imported by the interfaces and all modules.
package cbad_pkg;

    localparam int FIELD_BITS  = 12;   // width of each sample field
    localparam int NUM_FIELDS  = 4;    // sample fields on the request channel
    localparam int MASK_W      = 4;    // width of active_mask
    localparam int MAX_SENSORS = 8;
    localparam int CNT_W       = 9;    // frame counts and frame counter
    localparam int CNT_MAX     = 256;
    localparam int REDUCER_W   = 12;
    localparam int HOLD_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        K_TICK  = 2'd0,
        K_FRAME = 2'd1,
        K_CAL   = 2'd2,
        K_RSVD  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT  = 2'd0,
        CFG_CAL     = 2'd1,
        CFG_REDUCER = 2'd2,
        CFG_HOLDOFF = 2'd3
    } t_cfg_idx;

    typedef logic [FIELD_BITS-1:0] t_fields [NUM_FIELDS];

    typedef struct packed {
        logic capture;
        logic exec;
        logic div_step;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic blk_end;
        logic div_last;
    } t_status;

    typedef struct packed {
        logic              decision_valid;
        logic [MASK_W-1:0] active_mask;
        logic              calibration_done;
        logic              frame_dropped;
        logic              calibrating;
    } t_result;

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if (v > CNT_W'(CNT_MAX))
            r = CNT_W'(CNT_MAX);
        else
            r = v;
        return r;
    endfunction

endpackage

FILE: rtl/cbad_in_if.sv
`timescale 1ns / 1ps
// Request channel: kind plus four sample fields, valid/ready.
// Depends on cbad_pkg.
interface cbad_in_if import cbad_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [FIELD_BITS-1:0] sample_0;
    logic [FIELD_BITS-1:0] sample_1;
    logic [FIELD_BITS-1:0] sample_2;
    logic [FIELD_BITS-1:0] sample_3;

    modport source (output valid, kind, sample_0, sample_1, sample_2, sample_3,
                    input ready);
    modport sink   (input valid, kind, sample_0, sample_1, sample_2, sample_3,
                    output ready);
endinterface

FILE: rtl/cbad_out_if.sv
`timescale 1ns / 1ps
// Result channel: one result per request, valid/ready.
// Depends on cbad_pkg.
interface cbad_out_if import cbad_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              decision_valid;
    logic [MASK_W-1:0] active_mask;
    logic              calibration_done;
    logic              frame_dropped;
    logic              calibrating;

    modport source (output valid, decision_valid, active_mask, calibration_done,
                    frame_dropped, calibrating, input ready);
    modport sink   (input valid, decision_valid, active_mask, calibration_done,
                    frame_dropped, calibrating, output ready);
endinterface

FILE: rtl/calibrated_block_average_detector.sv
`timescale 1ns / 1ps
// Channel     Dir  Handshake    Payload
// i_in_ch     in   valid/ready  kind, sample_0..sample_3
// o_out_ch    out  valid/ready  decision_valid, active_mask, calibration_done,
//                               frame_dropped, calibrating
// i_cfg_*     in   write enable detect_count, cal_count, reducer, holdoff_ticks
//
// One request in flight. Ticks, calibration requests and frames that do not
// close a block go from accept through the execute and publish steps; a frame
// that closes a block also passes the divide and finish steps, in which the
// bit-serial restoring divider runs once per sensor lane in parallel.
// A new request is accepted while the previous result waits in the output
// register. Reset is synchronous, active low; no clearing pass is needed.
// Top level of the detector; depends on cbad_pkg, the channel interfaces,
// cbad_ctrl and cbad_dp.
module calibrated_block_average_detector import cbad_pkg::*; #(
    parameter int NUM_SENSORS = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cbad_in_if.sink               i_in_ch,
    cbad_out_if.source            o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    t_result result;
    t_fields fields;

    assign fields[0] = i_in_ch.sample_0;
    assign fields[1] = i_in_ch.sample_1;
    assign fields[2] = i_in_ch.sample_2;
    assign fields[3] = i_in_ch.sample_3;

    cbad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cbad_dp #(
        .NUM_SENSORS (NUM_SENSORS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_kind     (i_in_ch.kind),
        .i_fields   (fields),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    assign o_out_ch.decision_valid   = result.decision_valid;
    assign o_out_ch.active_mask      = result.active_mask;
    assign o_out_ch.calibration_done = result.calibration_done;
    assign o_out_ch.frame_dropped    = result.frame_dropped;
    assign o_out_ch.calibrating      = result.calibrating;

endmodule

FILE: rtl/cbad_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the detector: accept, execute, divide, finish, publish.
// Depends on cbad_pkg and the assertion macro header.
`include "calibrated_block_average_detector_assert.svh"

module cbad_ctrl import cbad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_FINISH,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.blk_end ? S_DIV : S_RESULT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                // wait for the output register to free up
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.load_out)
            n_out_vld = 1'b1;
        else if (i_out_ready)
            n_out_vld = 1'b0;
        else
            n_out_vld = r_out_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    `CBAD_ASSERT(a_load_free, i_clk, i_rst_n, o_cmd.load_out |-> (!r_out_vld || i_out_ready), "result loaded over a pending one")
    `CBAD_ASSERT(a_rose_from_result, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_state == S_RESULT), "result valid outside publish step")
    `CBAD_ASSERT_NEXT(a_div_follows, i_clk, i_rst_n, (r_state == S_EXEC) && i_status.blk_end, r_state == S_DIV, "block end did not start the divider")

endmodule

FILE: rtl/cbad_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, per-sensor sums, thresholds, counters,
// one restoring divider per sensor and the result register. Depends on cbad_pkg.
`include "calibrated_block_average_detector_assert.svh"

module cbad_dp import cbad_pkg::*; #(
    parameter int NUM_SENSORS = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic [1:0]            i_kind,
    input  t_fields               i_fields,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_result               o_result
);

    localparam int SW = SAMPLE_BITS + CNT_W - 1;   // sum of up to 256 frames
    localparam int DW = $clog2(SW);

    // configuration
    logic [CNT_W-1:0]     r_detect_count, r_cal_count;
    logic [REDUCER_W-1:0] r_reducer;
    logic [HOLD_W-1:0]    r_holdoff_ticks;

    // block state
    logic                   r_mode;
    logic [SW-1:0]          r_sum [NUM_SENSORS];
    logic [SW-1:0]          r_thr [NUM_SENSORS];
    logic [CNT_W-1:0]       r_fc;
    logic [HOLD_W-1:0]      r_hold;

    // captured request
    t_kind                  r_kind;
    logic [SAMPLE_BITS-1:0] r_samp [NUM_SENSORS];

    // divider
    logic [CNT_W-1:0]       r_n;
    logic                   r_is_cal;
    logic [SW-1:0]          r_dq  [NUM_SENSORS];
    logic [CNT_W-1:0]       r_rem [NUM_SENSORS];
    logic [DW-1:0]          r_dcnt;

    // per-request flags and result
    logic                   r_valid, r_done, r_drop;
    logic [MASK_W-1:0]      r_mask;
    t_result                r_res;

    logic [SAMPLE_BITS-1:0] samp_in [NUM_SENSORS];
    logic [SW-1:0]          sum_add [NUM_SENSORS];
    logic [CNT_W-1:0]       rem_nx  [NUM_SENSORS];
    logic                   q_bit   [NUM_SENSORS];
    logic [SW-1:0]          thr_nx  [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] hit;
    logic [MAX_SENSORS-1:0] hit_wide;
    logic [CNT_W-1:0]       n_sel;
    logic [CNT_W:0]         fc_inc;
    logic                   accum;
    logic                   blk_end;

    // sensors past the request fields read as zero
    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
        if (g < NUM_FIELDS) begin : g_fld
            assign samp_in[g] = SAMPLE_BITS'(32'(i_fields[g]));
        end else begin : g_zero
            assign samp_in[g] = '0;
        end
    end

    always_comb begin
        logic [CNT_W:0] t;
        n_sel   = r_mode ? eff_count(r_cal_count) : eff_count(r_detect_count);
        accum   = (r_kind == K_FRAME) && (r_mode || (r_hold == '0));
        fc_inc  = {1'b0, r_fc} + (CNT_W+1)'(1);
        blk_end = accum && (fc_inc >= {1'b0, n_sel});
        for (int i = 0; i < NUM_SENSORS; i++) begin
            sum_add[i] = r_sum[i] + SW'(r_samp[i]);
            // one restoring step
            t          = {r_rem[i], r_dq[i][SW-1]};
            q_bit[i]   = (t >= {1'b0, r_n});
            rem_nx[i]  = q_bit[i] ? CNT_W'(t - {1'b0, r_n}) : CNT_W'(t);
            thr_nx[i]  = (r_dq[i] > SW'(r_reducer)) ? r_dq[i] - SW'(r_reducer) : '0;
            hit[i]     = (r_dq[i] < r_thr[i]);
        end
        hit_wide = MAX_SENSORS'(hit);
    end

    assign o_status.blk_end  = blk_end;
    assign o_status.div_last = (r_dcnt == DW'(SW - 1));

    // control-type state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_count  <= CNT_W'(16);
            r_cal_count     <= CNT_W'(64);
            r_reducer       <= REDUCER_W'(100);
            r_holdoff_ticks <= HOLD_W'(1000);
            r_mode          <= 1'b1;
            r_fc            <= '0;
            r_hold          <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_sum[i] <= '0;
                r_thr[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_DETECT:  r_detect_count  <= i_cfg_data[CNT_W-1:0];
                    CFG_CAL:     r_cal_count     <= i_cfg_data[CNT_W-1:0];
                    CFG_REDUCER: r_reducer       <= i_cfg_data[REDUCER_W-1:0];
                    CFG_HOLDOFF: r_holdoff_ticks <= i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.exec) begin
                unique case (r_kind)
                    K_TICK: begin
                        if (!r_mode && (r_hold != '0)) r_hold <= r_hold - HOLD_W'(1);
                    end
                    K_CAL: begin
                        r_mode <= 1'b1;
                        r_fc   <= '0;
                        r_hold <= '0;
                        for (int i = 0; i < NUM_SENSORS; i++) r_sum[i] <= '0;
                    end
                    K_FRAME: begin
                        if (accum) begin
                            if (blk_end) begin
                                // sums go to the divider, block restarts
                                r_fc   <= '0;
                                r_mode <= 1'b0;
                                for (int i = 0; i < NUM_SENSORS; i++) r_sum[i] <= '0;
                            end else begin
                                r_fc <= fc_inc[CNT_W-1:0];
                                for (int i = 0; i < NUM_SENSORS; i++) r_sum[i] <= sum_add[i];
                            end
                        end
                    end
                    default: ;
                endcase
            end

            if (i_cmd.finish) begin
                if (r_is_cal) begin
                    for (int i = 0; i < NUM_SENSORS; i++) r_thr[i] <= thr_nx[i];
                end else if (hit != '0) begin
                    r_hold <= r_holdoff_ticks;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            for (int i = 0; i < NUM_SENSORS; i++) r_samp[i] <= samp_in[i];
        end

        if (i_cmd.exec) begin
            r_valid  <= blk_end && !r_mode;
            r_done   <= blk_end && r_mode;
            r_drop   <= (r_kind == K_FRAME) && !r_mode && (r_hold != '0);
            r_mask   <= '0;
            r_is_cal <= r_mode;
            r_n      <= n_sel;
            r_dcnt   <= '0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_dq[i]  <= sum_add[i];
                r_rem[i] <= '0;
            end
        end

        if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + DW'(1);
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_dq[i]  <= {r_dq[i][SW-2:0], q_bit[i]};
                r_rem[i] <= rem_nx[i];
            end
        end

        if (i_cmd.finish && !r_is_cal)
            r_mask <= hit_wide[MASK_W-1:0];

        if (i_cmd.load_out) begin
            r_res.decision_valid   <= r_valid;
            r_res.active_mask      <= r_mask;
            r_res.calibration_done <= r_done;
            r_res.frame_dropped    <= r_drop;
            r_res.calibrating      <= r_mode;
        end
    end

    assign o_result = r_res;

    `CBAD_ASSERT(a_fc_range, i_clk, i_rst_n, !r_fc[CNT_W-1], "frame counter past block length")
    `CBAD_ASSERT(a_hold_detect, i_clk, i_rst_n, (r_hold != '0) |-> !r_mode, "holdoff running in calibration mode")
    `CBAD_ASSERT_NEXT(a_cal_sets_mode, i_clk, i_rst_n, i_cmd.exec && (r_kind == K_CAL), r_mode && (r_fc == '0), "calibration request did not restart")
    `CBAD_ASSERT(a_div_bound, i_clk, i_rst_n, i_cmd.div_step |-> (r_dcnt < DW'(SW)), "divider stepped past its width")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for calibrated_block_average_detector: random-stall driver and
// monitor around the DUT, checked against an in-bench prediction of every result.
// Depends on cbad_pkg, cbad_in_if, cbad_out_if and the detector RTL.
module tb_top;
    import cbad_pkg::*;

    localparam int LANES     = 4;
    localparam int MAX_CYCLE = 600000;
    localparam int LONG_HOLD = 400;

    typedef logic [LANES-1:0][FIELD_BITS-1:0] t_frame;

    typedef struct packed {
        t_kind  kind;
        t_frame smp;
    } t_req;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    cbad_in_if  req_ch ();
    cbad_out_if res_ch ();

    calibrated_block_average_detector DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_ch    (req_ch),
        .o_out_ch   (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    t_req    pending_reqs [$];
    t_result expected_results [$];
    int      pushed;
    int      errors;
    int      cycles;
    bit      no_idle;
    bit      hold_now;
    bit      long_done;
    int      send_gap;
    int      rx_hold;

    // predicted detector state and register copies
    logic              in_cal;
    logic [19:0]       lane_sum [LANES];
    logic [19:0]       lane_thr [LANES];   // a lowered cal count can push it past 12 bits
    logic [CNT_W-1:0]  blk_frames;
    logic [HOLD_W-1:0] hold_left;
    logic [CNT_W-1:0]  det_len;
    logic [CNT_W-1:0]  cal_len;
    logic [REDUCER_W-1:0] reducer;
    logic [HOLD_W-1:0] hold_len;

    function automatic logic [CNT_W-1:0] block_len(logic [CNT_W-1:0] c);
        if (c == '0)
            return CNT_W'(1);
        return (c > CNT_W'(CNT_MAX)) ? CNT_W'(CNT_MAX) : c;
    endfunction

    function automatic t_result predict_detection(t_kind k, t_frame smp);
        t_result r;
        logic [CNT_W-1:0] n;
        logic [19:0] mean;
        r = '0;
        case (k)
            K_TICK: begin
                if (!in_cal && hold_left != '0)
                    hold_left = hold_left - 1'b1;
            end
            K_CAL: begin
                in_cal = 1'b1;
                lane_sum = '{default: '0};
                blk_frames = '0;
                hold_left = '0;
            end
            K_FRAME: begin
                if (in_cal || hold_left == '0) begin
                    n = block_len(in_cal ? cal_len : det_len);
                    for (int i = 0; i < LANES; i++)
                        lane_sum[i] = lane_sum[i] + smp[i];
                    blk_frames = blk_frames + 1'b1;
                    if (blk_frames >= n) begin
                        for (int i = 0; i < LANES; i++) begin
                            mean = lane_sum[i] / n;
                            if (in_cal)
                                lane_thr[i] = (mean > reducer) ? mean - reducer : '0;
                            else if (mean < lane_thr[i])
                                r.active_mask[i] = 1'b1;
                            lane_sum[i] = '0;
                        end
                        if (in_cal) begin
                            r.calibration_done = 1'b1;
                            in_cal = 1'b0;
                        end else begin
                            r.decision_valid = 1'b1;
                            if (r.active_mask != '0)
                                hold_left = hold_len;
                        end
                        blk_frames = '0;
                    end
                end else begin
                    r.frame_dropped = 1'b1;
                end
            end
            default: ;
        endcase
        r.calibrating = in_cal;
        return r;
    endfunction

    // ---------------- request driver ----------------
    always @(posedge clk) begin
        t_req nxt;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(predict_detection(t_kind'(req_ch.kind),
                    {req_ch.sample_3, req_ch.sample_2, req_ch.sample_1, req_ch.sample_0}));
                if (!no_idle && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 18);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    nxt = pending_reqs.pop_front();
                    req_ch.kind     <= nxt.kind;
                    req_ch.sample_0 <= nxt.smp[0];
                    req_ch.sample_1 <= nxt.smp[1];
                    req_ch.sample_2 <= nxt.smp[2];
                    req_ch.sample_3 <= nxt.smp[3];
                    req_ch.valid    <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result monitor ----------------
    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin
        t_result want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result mismatch, expected none, actual %b_%h_%b_%b_%b", $time,
                             res_ch.decision_valid, res_ch.active_mask,
                             res_ch.calibration_done, res_ch.frame_dropped, res_ch.calibrating);
                end else begin
                    want = expected_results.pop_front();
                    check_field("decision_valid", want.decision_valid, res_ch.decision_valid);
                    check_field("active_mask", want.active_mask, res_ch.active_mask);
                    check_field("calibration_done", want.calibration_done,
                                res_ch.calibration_done);
                    check_field("frame_dropped", want.frame_dropped, res_ch.frame_dropped);
                    check_field("calibrating", want.calibrating, res_ch.calibrating);
                end
            end
            // one long back-pressure stretch while requests keep coming
            if (hold_now && !long_done) begin
                long_done = 1'b1;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                res_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                rx_hold = $urandom_range(0, 17);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > MAX_CYCLE) begin
            $display("calibrated_block_average_detector verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic push_req(t_kind k, t_frame smp);
        t_req r;
        r.kind = k;
        r.smp  = smp;
        pending_reqs.push_back(r);
        pushed++;
    endtask

    function automatic t_frame rand_frame();
        t_frame f;
        for (int i = 0; i < LANES; i++)
            f[i] = FIELD_BITS'($urandom);
        return f;
    endfunction

    function automatic t_frame near_frame(logic [FIELD_BITS-1:0] base [LANES]);
        t_frame f;
        int v;
        for (int i = 0; i < LANES; i++) begin
            v = int'(base[i]) + int'($urandom_range(0, 120)) - 60;
            f[i] = (v < 0) ? '0 : (v > 4095) ? 12'd4095 : FIELD_BITS'(v);
        end
        return f;
    endfunction

    // each lane either well below its level (likely active) or near it
    function automatic t_frame mixed_frame(logic [FIELD_BITS-1:0] base [LANES]);
        t_frame f;
        f = near_frame(base);
        for (int i = 0; i < LANES; i++)
            if ($urandom_range(0, 1) == 0)
                f[i] = FIELD_BITS'($urandom_range(0, base[i] / 2));
        return f;
    endfunction

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DETECT:  det_len  = val[CNT_W-1:0];
            CFG_CAL:     cal_len  = val[CNT_W-1:0];
            CFG_REDUCER: reducer  = val[REDUCER_W-1:0];
            CFG_HOLDOFF: hold_len = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return CNT_W'(1);
        return CNT_W'($urandom_range(2, 8));
    endfunction

    task automatic random_phase(int n_items);
        logic [FIELD_BITS-1:0] base [LANES];
        int sel;
        int n_cal;
        wait_idle();
        write_reg(CFG_DETECT, CFG_DATA_W'(pick_count()));
        write_reg(CFG_CAL, CFG_DATA_W'(pick_count()));
        sel = $urandom_range(0, 9);
        write_reg(CFG_REDUCER, (sel == 0) ? 16'd0 : (sel == 1) ? 16'd4095 :
                               16'($urandom_range(0, 400)));
        sel = $urandom_range(0, 31);
        write_reg(CFG_HOLDOFF, (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'($urandom) :
                               (sel == 2) ? 16'd0 : 16'($urandom_range(1, 25)));
        for (int i = 0; i < LANES; i++)
            base[i] = FIELD_BITS'($urandom_range(300, 4095));
        n_cal = block_len(cal_len);
        if ($urandom_range(0, 3) != 0)
            push_req(K_CAL, rand_frame());
        repeat (n_cal) push_req(K_FRAME, near_frame(base));
        repeat (n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                push_req(K_FRAME, near_frame(base));
            else if (sel < 45)
                push_req(K_FRAME, mixed_frame(base));
            else if (sel < 55)
                push_req(K_FRAME, rand_frame());
            else if (sel < 85)
                push_req(K_TICK, rand_frame());
            else if (sel < 92) begin
                push_req(K_CAL, rand_frame());
                repeat (n_cal) push_req(K_FRAME, near_frame(base));
            end else
                push_req(K_RSVD, rand_frame());
        end
    endtask

    initial begin
        logic [FIELD_BITS-1:0] base [LANES];
        req_ch.valid    = 1'b0;
        req_ch.kind     = K_TICK;
        req_ch.sample_0 = '0;
        req_ch.sample_1 = '0;
        req_ch.sample_2 = '0;
        req_ch.sample_3 = '0;
        res_ch.ready    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_DETECT;
        cfg_data = '0;
        rst_n    = 1'b0;
        in_cal     = 1'b1;
        lane_sum   = '{default: '0};
        lane_thr   = '{default: '0};
        blk_frames = '0;
        hold_left  = '0;
        det_len    = CNT_W'(16);
        cal_len    = CNT_W'(64);
        reducer    = REDUCER_W'(100);
        hold_len   = HOLD_W'(1000);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values, unused kind, tick while calibrating
        push_req(K_RSVD, rand_frame());
        push_req(K_TICK, rand_frame());
        push_req(K_FRAME, {4{12'd4095}});
        push_req(K_FRAME, '0);
        push_req(K_CAL, rand_frame());
        // zero count acts as one, zero reducer, zero holdoff
        wait_idle();
        write_reg(CFG_CAL, 16'd0);
        write_reg(CFG_DETECT, 16'd1);
        write_reg(CFG_REDUCER, 16'd0);
        write_reg(CFG_HOLDOFF, 16'd0);
        push_req(K_FRAME, {4{12'd4095}});
        push_req(K_FRAME, '0);
        push_req(K_FRAME, {4{12'd4095}});
        push_req(K_FRAME, {12'd4094, 12'd100, 12'd4095, 12'd0});
        push_req(K_TICK, rand_frame());
        // holdoff: frames dropped until ticks count it down
        wait_idle();
        write_reg(CFG_DETECT, 16'd2);
        write_reg(CFG_HOLDOFF, 16'd3);
        push_req(K_FRAME, '0);
        push_req(K_FRAME, '0);
        push_req(K_FRAME, '0);
        push_req(K_TICK, rand_frame());
        push_req(K_TICK, rand_frame());
        push_req(K_FRAME, '0);
        push_req(K_TICK, rand_frame());
        push_req(K_FRAME, {4{12'd4095}});
        // count lowered mid-block closes it on the next frame
        wait_idle();
        write_reg(CFG_DETECT, 16'd1);
        push_req(K_FRAME, {4{12'd4095}});
        push_req(K_CAL, rand_frame());
        push_req(K_TICK, rand_frame());
        // reducer above the mean clamps thresholds at zero
        wait_idle();
        write_reg(CFG_REDUCER, 16'd4095);
        write_reg(CFG_CAL, 16'd1);
        push_req(K_FRAME, {4{12'd4095}});
        push_req(K_FRAME, '0);
        push_req(K_RSVD, rand_frame());

        repeat (3) random_phase($urandom_range(20, 60));

        // longest blocks: count above maximum, then detection count cut mid-block
        wait_idle();
        write_reg(CFG_CAL, 16'd511);
        write_reg(CFG_DETECT, 16'd256);
        write_reg(CFG_REDUCER, 16'($urandom_range(0, 200)));
        write_reg(CFG_HOLDOFF, 16'd4);
        for (int i = 0; i < LANES; i++)
            base[i] = FIELD_BITS'($urandom_range(300, 4095));
        push_req(K_CAL, rand_frame());
        repeat (256) push_req(K_FRAME, near_frame(base));
        repeat (20) push_req(K_FRAME, mixed_frame(base));
        hold_now = 1'b1;
        wait_idle();
        write_reg(CFG_DETECT, 16'd1);
        push_req(K_FRAME, mixed_frame(base));
        repeat (6) push_req(($urandom_range(0, 1) == 0) ? K_TICK : K_FRAME, mixed_frame(base));

        while (pushed < 590)
            random_phase($urandom_range(20, 60));
        wait_idle();
        no_idle = 1'b1;
        random_phase(100);

        wait_idle();
        repeat (30) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("calibrated_block_average_detector verification clean");
        else
            $display("calibrated_block_average_detector verification failed");
        $finish;
    end

endmodule

FILE: calibrated_block_average_detector.f
+incdir+rtl
rtl/cbad_pkg.sv
rtl/cbad_in_if.sv
rtl/cbad_out_if.sv
rtl/cbad_ctrl.sv
rtl/cbad_dp.sv
rtl/calibrated_block_average_detector.sv
tb/tb_top.sv
